// File: src/assert_macros.svh
// Assertion macros shared by the stopwatch RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

// File: src/swlap_pkg.sv
// Package with the types, constants and digit font of the stopwatch core.
package swlap_pkg;

    localparam int unsigned MS_W   = 10;
    localparam int unsigned SEC_W  = 6;
    localparam int unsigned MIN_W  = 6;
    localparam int unsigned STEP_W = 9;

    localparam logic [STEP_W-1:0] MS_RESET_STEP = 9'd8;
    localparam logic [MS_W:0]     MS_PER_SECOND = 11'd1000;
    localparam logic [SEC_W-1:0]  SEC_LAST      = 6'd59;
    localparam logic [MIN_W-1:0]  MIN_LAST      = 6'd59;
    localparam logic [7:0]        DP_CLEAR      = 8'h7F;
    localparam logic [7:0]        SEG_ZERO      = 8'hC0;

    typedef struct packed {
        logic [7:0] sec_tens;
        logic [7:0] sec_ones;
        logic [7:0] tenths;
        logic [7:0] hundredths;
    } segs_t;

    localparam segs_t SEGS_RESET = '{
        sec_tens:   SEG_ZERO,
        sec_ones:   SEG_ZERO & DP_CLEAR,
        tenths:     SEG_ZERO,
        hundredths: SEG_ZERO
    };

    function automatic logic [7:0] digit_font(input logic [3:0] digit);
        logic [7:0] pattern;
        unique case (digit)
            4'd0:    pattern = 8'hC0;
            4'd1:    pattern = 8'hF9;
            4'd2:    pattern = 8'hA4;
            4'd3:    pattern = 8'hB0;
            4'd4:    pattern = 8'h99;
            4'd5:    pattern = 8'h92;
            4'd6:    pattern = 8'h83;
            4'd7:    pattern = 8'hF8;
            4'd8:    pattern = 8'h80;
            4'd9:    pattern = 8'h98;
            default: pattern = 8'hFF;
        endcase
        return pattern;
    endfunction

endpackage

// File: src/swlap_seg_encode.sv
// Splits the millisecond and second counts into digits and maps them to segment patterns.
module swlap_seg_encode (
    input  logic [swlap_pkg::MS_W-1:0]  ms,
    input  logic [swlap_pkg::SEC_W-1:0] sec,
    output swlap_pkg::segs_t            segs
);

    logic [15:0] ms_by_41;
    logic [17:0] ms_by_205;
    logic [13:0] sec_by_205;
    logic [3:0]  tenths;
    logic [6:0]  ms_div10;
    logic [3:0]  hundredths;
    logic [2:0]  sec_tens;
    logic [3:0]  sec_ones;

    // Division by 100 and by 10 through scaled reciprocals, exact over 0 to 999.
    assign ms_by_41   = 16'(ms) * 16'd41;
    assign ms_by_205  = 18'(ms) * 18'd205;
    assign sec_by_205 = 14'(sec) * 14'd205;

    assign tenths     = ms_by_41[15:12];
    assign ms_div10   = ms_by_205[17:11];
    assign hundredths = 4'(ms_div10 - 7'(tenths) * 7'd10);
    assign sec_tens   = sec_by_205[13:11];
    assign sec_ones   = 4'(sec - 6'(sec_tens) * 6'd10);

    assign segs.hundredths = swlap_pkg::digit_font(hundredths);
    assign segs.tenths     = swlap_pkg::digit_font(tenths);
    assign segs.sec_ones   = swlap_pkg::digit_font(sec_ones) & swlap_pkg::DP_CLEAR;
    assign segs.sec_tens   = swlap_pkg::digit_font({1'b0, sec_tens});

endmodule

// File: src/stopwatch_lap_seven_segment_core.sv
// Top level of the stopwatch core with lap hold and seven-segment patterns.
//
//   channel  direction  handshake                    payload
//   tick     in         tick_valid / tick_stall      start_lap_n, reset_n
//   result   out        result_valid / result_stall  seg_*, running, display_live,
//                                                    minutes, seconds, millis
//   config   in         ms_per_tick_we               ms_per_tick_wdata
//
// A tick transaction is registered in the input register, then processed into the state
// registers, which drive the result ports directly; one transaction per cycle is
// sustained while result_stall is low, and the result is valid once the state registers take it.
// Reset sets the counters to zero, arms the buttons and shows 00.00.
// A stalled result holds the state; the input register still takes one tick,
// after which tick_stall follows result_stall.
module stopwatch_lap_seven_segment_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           ms_per_tick_we,
    input  logic [swlap_pkg::STEP_W-1:0]   ms_per_tick_wdata,
    input  logic                           tick_valid,
    output logic                           tick_stall,
    input  logic                           start_lap_n,
    input  logic                           reset_n,
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic [7:0]                     seg_hundredths,
    output logic [7:0]                     seg_tenths,
    output logic [7:0]                     seg_sec_ones,
    output logic [7:0]                     seg_sec_tens,
    output logic                           running,
    output logic                           display_live,
    output logic [swlap_pkg::MIN_W-1:0]    minutes,
    output logic [swlap_pkg::SEC_W-1:0]    seconds,
    output logic [swlap_pkg::MS_W-1:0]     millis
);

`include "assert_macros.svh"

    logic [swlap_pkg::STEP_W-1:0] step_reg;
    logic                         stage_valid_reg, stage_valid_next;
    logic                         lap_n_reg, rst_btn_n_reg;
    logic                         result_valid_reg, result_valid_next;
    logic [swlap_pkg::MS_W-1:0]   ms_reg, ms_next;
    logic [swlap_pkg::SEC_W-1:0]  sec_reg, sec_next;
    logic [swlap_pkg::MIN_W-1:0]  min_reg, min_next;
    logic                         armed_reg, armed_next;
    logic                         run_reg, run_next;
    logic                         live_reg, live_next;
    swlap_pkg::segs_t             shown_reg, shown_next;

    logic                         accept;
    logic                         advance;
    logic                         lap_pressed, rst_pressed;
    logic                         clear_now;
    logic [swlap_pkg::MS_W-1:0]   ms_base;
    logic [swlap_pkg::SEC_W-1:0]  sec_base;
    logic [swlap_pkg::MIN_W-1:0]  min_base;
    logic [swlap_pkg::MS_W:0]     ms_sum;
    logic                         ms_carry;
    logic [swlap_pkg::MS_W-1:0]   ms_adv;
    logic [swlap_pkg::SEC_W-1:0]  sec_adv;
    logic [swlap_pkg::MIN_W-1:0]  min_adv;
    logic [swlap_pkg::MS_W-1:0]   enc_ms;
    logic [swlap_pkg::SEC_W-1:0]  enc_sec;
    swlap_pkg::segs_t             enc_segs;

    assign advance    = stage_valid_reg && (!result_valid_reg || !result_stall);
    assign tick_stall = stage_valid_reg && result_valid_reg && result_stall;
    assign accept     = tick_valid && !tick_stall;

    assign lap_pressed = !lap_n_reg;
    assign rst_pressed = !rst_btn_n_reg;
    assign clear_now   = armed_reg && !lap_pressed && rst_pressed;

    assign ms_base  = clear_now ? '0 : ms_reg;
    assign sec_base = clear_now ? '0 : sec_reg;
    assign min_base = clear_now ? '0 : min_reg;

    assign ms_sum   = {1'b0, ms_base} + (swlap_pkg::MS_W + 1)'(step_reg);
    assign ms_carry = ms_sum >= swlap_pkg::MS_PER_SECOND;

    always_comb
    begin
        ms_adv  = ms_carry ? swlap_pkg::MS_W'(ms_sum - swlap_pkg::MS_PER_SECOND)
                           : swlap_pkg::MS_W'(ms_sum);
        sec_adv = sec_base;
        min_adv = min_base;
        if (ms_carry)
        begin
            if (sec_base == swlap_pkg::SEC_LAST)
            begin
                sec_adv = '0;
                min_adv = (min_base == swlap_pkg::MIN_LAST) ? '0 : min_base + 1'b1;
            end
            else
            begin
                sec_adv = sec_base + 1'b1;
            end
        end
    end

    // A reset press captures the time before it is cleared.
    assign enc_ms  = clear_now ? ms_reg  : ms_adv;
    assign enc_sec = clear_now ? sec_reg : sec_adv;

    swlap_seg_encode u_seg_encode (
        .ms   (enc_ms),
        .sec  (enc_sec),
        .segs (enc_segs)
    );

    always_comb
    begin
        armed_next = armed_reg;
        run_next   = run_reg;
        live_next  = live_reg;
        ms_next    = ms_reg;
        sec_next   = sec_reg;
        min_next   = min_reg;
        shown_next = shown_reg;
        if (advance)
        begin
            priority if (armed_reg && lap_pressed)
            begin
                run_next   = 1'b1;
                live_next  = !live_reg;
                armed_next = 1'b0;
            end
            else if (clear_now)
            begin
                run_next   = 1'b0;
                live_next  = 1'b0;
                armed_next = 1'b0;
                ms_next    = '0;
                sec_next   = '0;
                min_next   = '0;
            end
            else if (!armed_reg && !lap_pressed && !rst_pressed)
            begin
                armed_next = 1'b1;
            end
            else
            begin
                armed_next = armed_reg;
            end

            if (run_next)
            begin
                ms_next  = ms_adv;
                sec_next = sec_adv;
                min_next = min_adv;
            end

            if (clear_now || (run_next && live_next))
            begin
                shown_next = enc_segs;
            end
        end
    end

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (advance)
        begin
            stage_valid_next = 1'b0;
        end

        result_valid_next = result_valid_reg;
        if (advance)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg         <= swlap_pkg::MS_RESET_STEP;
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
            ms_reg           <= '0;
            sec_reg          <= '0;
            min_reg          <= '0;
            armed_reg        <= 1'b1;
            run_reg          <= 1'b0;
            live_reg         <= 1'b0;
            shown_reg        <= swlap_pkg::SEGS_RESET;
        end
        else
        begin
            if (ms_per_tick_we)
            begin
                step_reg <= ms_per_tick_wdata;
            end
            stage_valid_reg  <= stage_valid_next;
            result_valid_reg <= result_valid_next;
            ms_reg           <= ms_next;
            sec_reg          <= sec_next;
            min_reg          <= min_next;
            armed_reg        <= armed_next;
            run_reg          <= run_next;
            live_reg         <= live_next;
            shown_reg        <= shown_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lap_n_reg     <= start_lap_n;
            rst_btn_n_reg <= reset_n;
        end
    end

    assign result_valid   = result_valid_reg;
    assign seg_hundredths = shown_reg.hundredths;
    assign seg_tenths     = shown_reg.tenths;
    assign seg_sec_ones   = shown_reg.sec_ones;
    assign seg_sec_tens   = shown_reg.sec_tens;
    assign running        = run_reg;
    assign display_live   = live_reg;
    assign minutes        = min_reg;
    assign seconds        = sec_reg;
    assign millis         = ms_reg;

    `ASSERT_IMPLIES(a_counts_in_range, clk, rst_n, 1'b1,
        (ms_reg < 10'd1000) && (sec_reg <= swlap_pkg::SEC_LAST) && (min_reg <= swlap_pkg::MIN_LAST))
    `ASSERT_IMPLIES(a_live_needs_run, clk, rst_n, live_reg, run_reg)
    `ASSERT_IMPLIES(a_full_stage_blocks, clk, rst_n,
        stage_valid_reg && result_valid_reg && result_stall, tick_stall && !advance)
    `ASSERT_NEXT(a_advance_gives_result, clk, rst_n, advance, result_valid)

endmodule
